@@ rtl/nps_pkg.sv @@
`timescale 1ns / 1ps
// Package: widths, register indexes and shared types of the periodic image search.
package nps_pkg;

    localparam int POS_W     = 24;
    localparam int POS_FRAC  = 20;
    localparam int REF_W     = 8;
    localparam int NEAR_W    = 9;
    localparam int G_W       = 32;
    localparam int PFLD_W    = 6;
    localparam int PER_W     = 7;
    localparam int PP_W      = 14;
    localparam int MAX_PERIOD = 64;
    localparam int CFG_W     = 32;
    localparam int IDX_W     = 3;
    localparam int NCELL     = 27;

    // e = tau_i - tau_j - ref * one
    localparam int E_W  = POS_W + 5;
    localparam int PR_W = G_W + E_W;
    localparam int V_W  = PR_W + 2;
    localparam int W_W  = V_W + PER_W + 1;
    localparam int A_W  = G_W + PP_W + 1;
    localparam int F_W  = 76;

    localparam logic signed [F_W-1:0] F_MAX = {1'b0, {(F_W-1){1'b1}}};

    localparam logic [IDX_W-1:0] REG_XX     = 3'd0;
    localparam logic [IDX_W-1:0] REG_YY     = 3'd1;
    localparam logic [IDX_W-1:0] REG_ZZ     = 3'd2;
    localparam logic [IDX_W-1:0] REG_XY     = 3'd3;
    localparam logic [IDX_W-1:0] REG_XZ     = 3'd4;
    localparam logic [IDX_W-1:0] REG_YZ     = 3'd5;
    localparam logic [IDX_W-1:0] REG_PERIOD = 3'd6;

    typedef struct packed {
        logic signed [POS_W-1:0] tau_i_x;
        logic signed [POS_W-1:0] tau_i_y;
        logic signed [POS_W-1:0] tau_i_z;
        logic signed [POS_W-1:0] tau_j_x;
        logic signed [POS_W-1:0] tau_j_y;
        logic signed [POS_W-1:0] tau_j_z;
        logic signed [REF_W-1:0] ref_x;
        logic signed [REF_W-1:0] ref_y;
        logic signed [REF_W-1:0] ref_z;
    } nps_item_t;

    typedef struct packed {
        logic signed [G_W-1:0] g_xx;
        logic signed [G_W-1:0] g_yy;
        logic signed [G_W-1:0] g_zz;
        logic signed [G_W-1:0] g_xy;
        logic signed [G_W-1:0] g_xz;
        logic signed [G_W-1:0] g_yz;
        logic [3*PFLD_W-1:0]   period;
    } nps_cfg_t;

    typedef struct packed {
        logic signed [A_W-1:0] a_xx;
        logic signed [A_W-1:0] a_yy;
        logic signed [A_W-1:0] a_zz;
        logic signed [A_W-1:0] a_xy;
        logic signed [A_W-1:0] a_xz;
        logic signed [A_W-1:0] a_yz;
        logic [PER_W-1:0]      p_x;
        logic [PER_W-1:0]      p_y;
        logic [PER_W-1:0]      p_z;
    } nps_metric_t;

    typedef struct packed {
        logic                     vld;
        logic signed [W_W-1:0]    w_x;
        logic signed [W_W-1:0]    w_y;
        logic signed [W_W-1:0]    w_z;
        logic signed [REF_W-1:0]  ref_x;
        logic signed [REF_W-1:0]  ref_y;
        logic signed [REF_W-1:0]  ref_z;
        logic signed [F_W-1:0]    best_f;
        logic signed [NEAR_W-1:0] best_x;
        logic signed [NEAR_W-1:0] best_y;
        logic signed [NEAR_W-1:0] best_z;
    } nps_tok_t;

endpackage

@@ rtl/nps_if.sv @@
`timescale 1ns / 1ps
// Interfaces: input and result channels of the periodic image search.
interface nps_in_if;
    logic                     valid;
    logic                     ready;
    logic signed [23:0]       tau_i_x;
    logic signed [23:0]       tau_i_y;
    logic signed [23:0]       tau_i_z;
    logic signed [23:0]       tau_j_x;
    logic signed [23:0]       tau_j_y;
    logic signed [23:0]       tau_j_z;
    logic signed [7:0]        ref_x;
    logic signed [7:0]        ref_y;
    logic signed [7:0]        ref_z;

    modport source (output valid, tau_i_x, tau_i_y, tau_i_z, tau_j_x, tau_j_y, tau_j_z,
                    ref_x, ref_y, ref_z, input ready);
    modport sink (input valid, tau_i_x, tau_i_y, tau_i_z, tau_j_x, tau_j_y, tau_j_z,
                  ref_x, ref_y, ref_z, output ready);
endinterface

interface nps_out_if;
    logic              valid;
    logic              ready;
    logic signed [8:0] near_x;
    logic signed [8:0] near_y;
    logic signed [8:0] near_z;

    modport source (output valid, near_x, near_y, near_z, input ready);
    modport sink (input valid, near_x, near_y, near_z, output ready);
endinterface

@@ rtl/nps_prep.sv @@
`timescale 1ns / 1ps
// Front end: offset vector, metric products and period scaling feeding the cell chain.
module nps_prep (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_vld,
    input  nps_pkg::nps_item_t item,
    input  nps_pkg::nps_cfg_t  cfg,
    output nps_pkg::nps_tok_t  tok,
    output nps_pkg::nps_metric_t met
);
    import nps_pkg::*;

    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [E_W-1:0]   ex_reg, ey_reg, ez_reg;
    logic signed [E_W-1:0]   ex_next, ey_next, ez_next;
    logic signed [REF_W-1:0] r1x_reg, r1y_reg, r1z_reg;
    logic signed [REF_W-1:0] r2x_reg, r2y_reg, r2z_reg;
    logic signed [REF_W-1:0] r3x_reg, r3y_reg, r3z_reg;
    logic signed [REF_W-1:0] r4x_reg, r4y_reg, r4z_reg;
    logic signed [PR_W-1:0]  pxx_reg, pxy_reg, pxz_reg;
    logic signed [PR_W-1:0]  pyx_reg, pyy_reg, pyz_reg;
    logic signed [PR_W-1:0]  pzx_reg, pzy_reg, pzz_reg;
    logic signed [V_W-1:0]   vx_reg, vy_reg, vz_reg;
    logic signed [W_W-1:0]   wx_reg, wy_reg, wz_reg;
    logic [PER_W-1:0]        px, py, pz;
    logic [PP_W-1:0]         ppxx_reg, ppyy_reg, ppzz_reg, ppxy_reg, ppxz_reg, ppyz_reg;
    nps_metric_t             met_reg;

    // period fields hold period minus one, so the period never exceeds MAX_PERIOD
    assign px = {1'b0, cfg.period[PFLD_W-1:0]} + PER_W'(1);
    assign py = {1'b0, cfg.period[2*PFLD_W-1:PFLD_W]} + PER_W'(1);
    assign pz = {1'b0, cfg.period[3*PFLD_W-1:2*PFLD_W]} + PER_W'(1);

    assign ex_next = E_W'(item.tau_i_x) - E_W'(item.tau_j_x) - (E_W'(item.ref_x) <<< POS_FRAC);
    assign ey_next = E_W'(item.tau_i_y) - E_W'(item.tau_j_y) - (E_W'(item.ref_y) <<< POS_FRAC);
    assign ez_next = E_W'(item.tau_i_z) - E_W'(item.tau_j_z) - (E_W'(item.ref_z) <<< POS_FRAC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ex_reg  <= ex_next;
            ey_reg  <= ey_next;
            ez_reg  <= ez_next;
            r1x_reg <= item.ref_x;
            r1y_reg <= item.ref_y;
            r1z_reg <= item.ref_z;
            pxx_reg <= PR_W'(cfg.g_xx * ex_reg);
            pxy_reg <= PR_W'(cfg.g_xy * ey_reg);
            pxz_reg <= PR_W'(cfg.g_xz * ez_reg);
            pyx_reg <= PR_W'(cfg.g_xy * ex_reg);
            pyy_reg <= PR_W'(cfg.g_yy * ey_reg);
            pyz_reg <= PR_W'(cfg.g_yz * ez_reg);
            pzx_reg <= PR_W'(cfg.g_xz * ex_reg);
            pzy_reg <= PR_W'(cfg.g_yz * ey_reg);
            pzz_reg <= PR_W'(cfg.g_zz * ez_reg);
            r2x_reg <= r1x_reg;
            r2y_reg <= r1y_reg;
            r2z_reg <= r1z_reg;
            vx_reg  <= V_W'(pxx_reg) + V_W'(pxy_reg) + V_W'(pxz_reg);
            vy_reg  <= V_W'(pyx_reg) + V_W'(pyy_reg) + V_W'(pyz_reg);
            vz_reg  <= V_W'(pzx_reg) + V_W'(pzy_reg) + V_W'(pzz_reg);
            r3x_reg <= r2x_reg;
            r3y_reg <= r2y_reg;
            r3z_reg <= r2z_reg;
            wx_reg  <= W_W'(vx_reg * $signed({1'b0, px}));
            wy_reg  <= W_W'(vy_reg * $signed({1'b0, py}));
            wz_reg  <= W_W'(vz_reg * $signed({1'b0, pz}));
            r4x_reg <= r3x_reg;
            r4y_reg <= r3y_reg;
            r4z_reg <= r3z_reg;
        end
    end

    // metric scaled by periods: period products, then the scaled metric, both registered
    always_ff @(posedge clk)
    begin
        ppxx_reg     <= PP_W'(px * px);
        ppyy_reg     <= PP_W'(py * py);
        ppzz_reg     <= PP_W'(pz * pz);
        ppxy_reg     <= PP_W'(px * py);
        ppxz_reg     <= PP_W'(px * pz);
        ppyz_reg     <= PP_W'(py * pz);
        met_reg.a_xx <= A_W'(cfg.g_xx * $signed({1'b0, ppxx_reg}));
        met_reg.a_yy <= A_W'(cfg.g_yy * $signed({1'b0, ppyy_reg}));
        met_reg.a_zz <= A_W'(cfg.g_zz * $signed({1'b0, ppzz_reg}));
        met_reg.a_xy <= A_W'(cfg.g_xy * $signed({1'b0, ppxy_reg}));
        met_reg.a_xz <= A_W'(cfg.g_xz * $signed({1'b0, ppxz_reg}));
        met_reg.a_yz <= A_W'(cfg.g_yz * $signed({1'b0, ppyz_reg}));
        met_reg.p_x  <= px;
        met_reg.p_y  <= py;
        met_reg.p_z  <= pz;
    end

    assign met = met_reg;

    always_comb
    begin
        tok.vld    = v4_reg;
        tok.w_x    = wx_reg;
        tok.w_y    = wy_reg;
        tok.w_z    = wz_reg;
        tok.ref_x  = r4x_reg;
        tok.ref_y  = r4y_reg;
        tok.ref_z  = r4z_reg;
        tok.best_f = F_MAX;
        tok.best_x = '0;
        tok.best_y = '0;
        tok.best_z = '0;
    end

endmodule

@@ rtl/nps_cell.sv @@
`timescale 1ns / 1ps
// Cell: scores one candidate offset and keeps the running best of the transaction.
module nps_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic signed [1:0]    ox,
    input  logic signed [1:0]    oy,
    input  logic signed [1:0]    oz,
    input  nps_pkg::nps_metric_t met,
    input  nps_pkg::nps_tok_t    tok_in,
    output nps_pkg::nps_tok_t    tok_out
);
    import nps_pkg::*;

    function automatic logic signed [F_W-1:0] tri_f(logic signed [1:0] o,
                                                    logic signed [F_W-1:0] v);
        logic signed [F_W-1:0] r;
        case (o)
            2'sd1:   r = v;
            -2'sd1:  r = -v;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic signed [NEAR_W-1:0] tri_p(logic signed [1:0] o,
                                                       logic [PER_W-1:0] p);
        logic signed [NEAR_W-1:0] r;
        case (o)
            2'sd1:   r = $signed(NEAR_W'(p));
            -2'sd1:  r = -$signed(NEAR_W'(p));
            default: r = '0;
        endcase
        return r;
    endfunction

    logic signed [F_W-1:0]    quad_reg, quad_next;
    logic signed [F_W-1:0]    f_reg, f_next, lin;
    nps_tok_t                 tok_a_reg, tok_b_reg, tok_b_next;
    logic signed [NEAR_W-1:0] cx, cy, cz;

    // candidate-only part of the score, refreshed from the metric every cycle
    always_comb
    begin
        quad_next = tri_f(ox, tri_f(ox, F_W'(met.a_xx)))
                  + tri_f(oy, tri_f(oy, F_W'(met.a_yy)))
                  + tri_f(oz, tri_f(oz, F_W'(met.a_zz)))
                  + ((tri_f(ox, tri_f(oy, F_W'(met.a_xy)))
                    + tri_f(ox, tri_f(oz, F_W'(met.a_xz)))
                    + tri_f(oy, tri_f(oz, F_W'(met.a_yz)))) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        quad_reg <= quad_next;
    end

    assign lin    = tri_f(ox, F_W'(tok_in.w_x)) + tri_f(oy, F_W'(tok_in.w_y))
                  + tri_f(oz, F_W'(tok_in.w_z));
    assign f_next = (quad_reg <<< POS_FRAC) - (lin <<< 1);

    assign cx = NEAR_W'(tok_a_reg.ref_x) + tri_p(ox, met.p_x);
    assign cy = NEAR_W'(tok_a_reg.ref_y) + tri_p(oy, met.p_y);
    assign cz = NEAR_W'(tok_a_reg.ref_z) + tri_p(oz, met.p_z);

    always_comb
    begin
        tok_b_next = tok_a_reg;
        if (f_reg < tok_a_reg.best_f)
        begin
            tok_b_next.best_f = f_reg;
            tok_b_next.best_x = cx;
            tok_b_next.best_y = cy;
            tok_b_next.best_z = cz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_a_reg.vld <= 1'b0;
            tok_b_reg.vld <= 1'b0;
        end
        else if (adv)
        begin
            tok_a_reg <= tok_in;
            tok_b_reg <= tok_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_reg <= f_next;
        end
    end

    assign tok_out = tok_b_reg;

endmodule

@@ rtl/nearest_periodic_image_search_unit.sv @@
`timescale 1ns / 1ps
// Top level: configuration registers, front end, chain of 27 candidate cells, output register.
// Pipeline: 59 register stages from the accepting edge to the output channel.
// Throughput: one transaction per cycle; the whole pipeline advances together and
// holds only while a finished result waits and the sink is not ready.
// Reset: clears all valid flags and loads the metric with identity and all periods with one.
// After a register write the period products and scaled metric settle ahead of any later item.
module nearest_periodic_image_search_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    nps_in_if.sink                    in_ch,
    nps_out_if.source                 out_ch,
    input  logic                      cfg_we,
    input  logic [nps_pkg::IDX_W-1:0] cfg_index,
    input  logic [nps_pkg::CFG_W-1:0] cfg_data
);
    import nps_pkg::*;

    nps_cfg_t                 cfg_reg;
    nps_item_t                item;
    nps_metric_t              met;
    nps_tok_t                 chain [0:NCELL];
    logic                     adv;
    logic                     out_vld_reg;
    logic signed [NEAR_W-1:0] near_x_reg, near_y_reg, near_z_reg;

    // advance everything unless a result waits unclaimed
    assign adv         = !out_vld_reg || out_ch.ready;
    assign in_ch.ready = adv;

    // configuration registers; an index beyond the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.g_xx   <= 32'sd65536;
            cfg_reg.g_yy   <= 32'sd65536;
            cfg_reg.g_zz   <= 32'sd65536;
            cfg_reg.g_xy   <= '0;
            cfg_reg.g_xz   <= '0;
            cfg_reg.g_yz   <= '0;
            cfg_reg.period <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_XX:     cfg_reg.g_xx   <= cfg_data;
                REG_YY:     cfg_reg.g_yy   <= cfg_data;
                REG_ZZ:     cfg_reg.g_zz   <= cfg_data;
                REG_XY:     cfg_reg.g_xy   <= cfg_data;
                REG_XZ:     cfg_reg.g_xz   <= cfg_data;
                REG_YZ:     cfg_reg.g_yz   <= cfg_data;
                REG_PERIOD: cfg_reg.period <= cfg_data[3*PFLD_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        item.tau_i_x = in_ch.tau_i_x;
        item.tau_i_y = in_ch.tau_i_y;
        item.tau_i_z = in_ch.tau_i_z;
        item.tau_j_x = in_ch.tau_j_x;
        item.tau_j_y = in_ch.tau_j_y;
        item.tau_j_z = in_ch.tau_j_z;
        item.ref_x   = in_ch.ref_x;
        item.ref_y   = in_ch.ref_y;
        item.ref_z   = in_ch.ref_z;
    end

    // offset vector, metric-times-offset and period scaling
    nps_prep u_prep (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .in_vld (in_ch.valid),
        .item   (item),
        .cfg    (cfg_reg),
        .tok    (chain[0]),
        .met    (met)
    );

    // one cell per candidate, x offset outermost, each offset from -1 to +1;
    // strict less-than in each cell keeps the earliest candidate on ties
    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        nps_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .ox      (2'(i / 9 - 1)),
            .oy      (2'((i / 3) % 3 - 1)),
            .oz      (2'(i % 3 - 1)),
            .met     (met),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    // output register: hold the result until the sink takes the transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= chain[NCELL].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            near_x_reg <= chain[NCELL].best_x;
            near_y_reg <= chain[NCELL].best_y;
            near_z_reg <= chain[NCELL].best_z;
        end
    end

    assign out_ch.valid  = out_vld_reg;
    assign out_ch.near_x = near_x_reg;
    assign out_ch.near_y = near_y_reg;
    assign out_ch.near_z = near_z_reg;

endmodule

@@ bench/tb_nearest_periodic_image_search_unit.sv @@
`timescale 1ns / 1ps
// Testbench: self-checking bench of the nearest periodic image search unit.
module tb_nearest_periodic_image_search_unit;
    import nps_pkg::*;

    typedef struct {
        logic signed [NEAR_W-1:0] x;
        logic signed [NEAR_W-1:0] y;
        logic signed [NEAR_W-1:0] z;
    } image_t;

    localparam int FIELD_MAX = 8388607;
    localparam int FIELD_MIN = -8388608;
    // Index past the end of the register list
    localparam logic [IDX_W-1:0] REG_NONE = 3'd7;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    nps_in_if  in_ch ();
    nps_out_if out_ch ();

    nearest_periodic_image_search_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the register file, kept in step with every write
    logic signed [G_W-1:0] metric_mirror [6];
    logic [3*PFLD_W-1:0]   period_mirror;

    image_t expected_images[$];
    int     errors       = 0;
    int     sent_items   = 0;
    int     checked      = 0;
    int     cfg_phases   = 0;
    // Idling: calm removes random gaps and stalls; hold_request asks for a long sink stall
    bit     calm         = 0;
    int     hold_request = 0;
    int     hold_left    = 0;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Timeout guard: far beyond the slowest legal run
    initial
    begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    // Work out the nearest image exactly: every term of the quadratic form fits in 128 bits
    function automatic image_t nearest_image(nps_item_t it);
        logic signed [127:0] g [6];
        logic signed [127:0] diff [3];
        logic signed [127:0] d [3];
        logic signed [127:0] q;
        logic signed [127:0] best_q;
        int     per [3];
        int     refv [3];
        int     c [3];
        image_t best;
        bit     have;
        have = 0;
        best = '{x: '0, y: '0, z: '0};
        best_q = '0;
        for (int i = 0; i < 6; i++)
        begin
            g[i] = 128'(metric_mirror[i]);
        end
        diff[0] = 128'(it.tau_i_x) - 128'(it.tau_j_x);
        diff[1] = 128'(it.tau_i_y) - 128'(it.tau_j_y);
        diff[2] = 128'(it.tau_i_z) - 128'(it.tau_j_z);
        refv[0] = int'(it.ref_x);
        refv[1] = int'(it.ref_y);
        refv[2] = int'(it.ref_z);
        for (int i = 0; i < 3; i++)
        begin
            per[i] = int'(period_mirror[PFLD_W*i +: PFLD_W]) + 1;
            if (per[i] > MAX_PERIOD)
            begin
                per[i] = MAX_PERIOD;
            end
        end
        // Scan x outermost, offsets -1..1; strict less-than keeps the earliest of equals
        for (int ox = -1; ox <= 1; ox++)
        begin
            for (int oy = -1; oy <= 1; oy++)
            begin
                for (int oz = -1; oz <= 1; oz++)
                begin
                    c[0] = refv[0] + ox * per[0];
                    c[1] = refv[1] + oy * per[1];
                    c[2] = refv[2] + oz * per[2];
                    for (int i = 0; i < 3; i++)
                    begin
                        d[i] = diff[i] - (128'(c[i]) <<< POS_FRAC);
                    end
                    q = g[0] * d[0] * d[0] + g[1] * d[1] * d[1] + g[2] * d[2] * d[2]
                        + 2 * (g[3] * d[0] * d[1] + g[4] * d[0] * d[2] + g[5] * d[1] * d[2]);
                    if (!have || q < best_q)
                    begin
                        have = 1;
                        best_q = q;
                        best.x = c[0][NEAR_W-1:0];
                        best.y = c[1][NEAR_W-1:0];
                        best.z = c[2][NEAR_W-1:0];
                    end
                end
            end
        end
        return best;
    endfunction

    // Result sink: random stalls, quiet stretches and a counted long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_left = 0;
        end
        else if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ch.ready <= 1'b0;
        end
        else
        begin
            out_ch.ready <= calm || ($urandom_range(99) >= 10);
        end
    end

    // Compare every result transaction with the oldest outstanding image
    image_t want;
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_images.size() == 0)
            begin
                $error("result with no outstanding item: %0d %0d %0d",
                       out_ch.near_x, out_ch.near_y, out_ch.near_z);
                errors++;
            end
            else
            begin
                want = expected_images.pop_front();
                checked++;
                if (out_ch.near_x !== want.x)
                begin
                    $error("near_x expected %0d actual %0d", want.x, out_ch.near_x);
                    errors++;
                end
                if (out_ch.near_y !== want.y)
                begin
                    $error("near_y expected %0d actual %0d", want.y, out_ch.near_y);
                    errors++;
                end
                if (out_ch.near_z !== want.z)
                begin
                    $error("near_z expected %0d actual %0d", want.z, out_ch.near_z);
                    errors++;
                end
            end
        end
    end

    // Offer one item, with an optional random gap first; record its image once accepted
    task automatic send_item(nps_item_t it);
        while (!calm && $urandom_range(99) < 10)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.tau_i_x <= it.tau_i_x;
        in_ch.tau_i_y <= it.tau_i_y;
        in_ch.tau_i_z <= it.tau_i_z;
        in_ch.tau_j_x <= it.tau_j_x;
        in_ch.tau_j_y <= it.tau_j_y;
        in_ch.tau_j_z <= it.tau_j_z;
        in_ch.ref_x   <= it.ref_x;
        in_ch.ref_y   <= it.ref_y;
        in_ch.ref_z   <= it.ref_z;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        expected_images.insert(expected_images.size(), nearest_image(it));
        sent_items++;
    endtask

    // Drop valid, drain every outstanding result and let the pipeline empty
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (expected_images.size() == 0);
        repeat (64) @(posedge clk);
    endtask

    // One write, then the enable drops and the bench idles before the next write
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_XX:     metric_mirror[0] = value;
            REG_YY:     metric_mirror[1] = value;
            REG_ZZ:     metric_mirror[2] = value;
            REG_XY:     metric_mirror[3] = value;
            REG_XZ:     metric_mirror[4] = value;
            REG_YZ:     metric_mirror[5] = value;
            REG_PERIOD: period_mirror = value[3*PFLD_W-1:0];
            default:    ; // beyond the register list: ignored by the block
        endcase
        @(posedge clk);
    endtask

    // Load the whole metric and the periods while the block is idle
    task automatic load_lattice(logic [G_W-1:0] xx, logic [G_W-1:0] yy, logic [G_W-1:0] zz,
                                logic [G_W-1:0] xy, logic [G_W-1:0] xz, logic [G_W-1:0] yz,
                                logic [3*PFLD_W-1:0] period);
        drain();
        write_reg(REG_XX, xx);
        write_reg(REG_YY, yy);
        write_reg(REG_ZZ, zz);
        write_reg(REG_XY, xy);
        write_reg(REG_XZ, xz);
        write_reg(REG_YZ, yz);
        write_reg(REG_PERIOD, CFG_W'(period));
        cfg_phases++;
    endtask

    function automatic nps_item_t make_item(int ti, int tj, int r);
        nps_item_t it;
        it.tau_i_x = POS_W'(ti);  it.tau_i_y = POS_W'(ti);  it.tau_i_z = POS_W'(ti);
        it.tau_j_x = POS_W'(tj);  it.tau_j_y = POS_W'(tj);  it.tau_j_z = POS_W'(tj);
        it.ref_x = REF_W'(r);     it.ref_y = REF_W'(r);     it.ref_z = REF_W'(r);
        return it;
    endfunction

    // Random item: mostly the reference sits near the true separation so the choice varies
    function automatic nps_item_t random_item();
        nps_item_t it;
        it.tau_i_x = POS_W'($urandom);  it.tau_i_y = POS_W'($urandom);
        it.tau_i_z = POS_W'($urandom);
        it.tau_j_x = POS_W'($urandom);  it.tau_j_y = POS_W'($urandom);
        it.tau_j_z = POS_W'($urandom);
        it.ref_x = REF_W'($urandom);    it.ref_y = REF_W'($urandom);
        it.ref_z = REF_W'($urandom);
        if ($urandom_range(99) < 70)
        begin
            it.ref_x = REF_W'(((int'(it.tau_i_x) - int'(it.tau_j_x)) >>> POS_FRAC)
                              + int'($urandom_range(4)) - 2);
            it.ref_y = REF_W'(((int'(it.tau_i_y) - int'(it.tau_j_y)) >>> POS_FRAC)
                              + int'($urandom_range(4)) - 2);
            it.ref_z = REF_W'(((int'(it.tau_i_z) - int'(it.tau_j_z)) >>> POS_FRAC)
                              + int'($urandom_range(4)) - 2);
        end
        return it;
    endfunction

    // Reset metric (identity, unit periods): field extremes and a few plain cases
    task automatic test_field_extremes();
        send_item(make_item(0, 0, 0));
        send_item(make_item(FIELD_MAX, FIELD_MIN, 127));
        send_item(make_item(FIELD_MIN, FIELD_MAX, -128));
        send_item(make_item(FIELD_MAX, FIELD_MAX, -128));
        send_item(make_item(FIELD_MIN, 0, 127));
        send_item(make_item(1 << POS_FRAC, 0, 0));
        send_item(make_item(-(1 << POS_FRAC), 0, 0));
        // Exactly half a period away: equal lengths, earliest candidate wins
        send_item(make_item(1 << (POS_FRAC - 1), 0, 0));
    endtask

    // Zero metric: every candidate ties, so the first one (all offsets -1) must come back
    task automatic test_ties_zero_metric();
        load_lattice('0, '0, '0, '0, '0, '0, 18'h0_1083);
        send_item(make_item(FIELD_MAX, FIELD_MIN, 5));
        send_item(make_item(123, -456, -128));
    endtask

    // Largest periods, largest output range, and a write beyond the register list
    task automatic test_period_extremes();
        load_lattice(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, '0, '0, '0, '1);
        write_reg(REG_NONE, $urandom);
        send_item(make_item(FIELD_MAX, FIELD_MIN, 127));
        send_item(make_item(FIELD_MIN, FIELD_MAX, -128));
        send_item(make_item(FIELD_MAX, FIELD_MIN, -128));
        send_item(make_item(0, 0, 127));
    endtask

    // Metric entries at their extremes, including an indefinite form
    task automatic test_metric_extremes();
        load_lattice(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 18'h3_0C30);
        send_item(make_item(FIELD_MAX, FIELD_MIN, 127));
        send_item(make_item(FIELD_MIN, FIELD_MAX, -128));
        send_item(make_item(12345, -54321, 3));
        load_lattice(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 18'h0_0000);
        send_item(make_item(FIELD_MAX, FIELD_MIN, 127));
        send_item(make_item(FIELD_MIN, FIELD_MAX, -128));
        send_item(make_item(-777, 999, -1));
    endtask

    // Random phases: sheared positive lattices most of the time, arbitrary metrics otherwise
    task automatic test_random_lattices(int phases, int per_phase);
        logic [G_W-1:0] diag [3];
        logic [G_W-1:0] off [3];
        for (int p = 0; p < phases; p++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (p % 4 == 3)
                begin
                    diag[i] = $urandom;
                    off[i]  = $urandom;
                end
                else
                begin
                    diag[i] = $urandom_range(32'h0040_0000, 32'h0000_4000);
                    off[i]  = int'($urandom_range(32'h0000_8000)) - 32'h0000_4000;
                end
            end
            load_lattice(diag[0], diag[1], diag[2], off[0], off[1], off[2],
                         (3*PFLD_W)'($urandom));
            // Hold the sender steady for one phase to test back-to-back throughput
            calm = (p == 2);
            for (int n = 0; n < per_phase; n++)
            begin
                send_item(random_item());
            end
            calm = 0;
        end
    endtask

    // Stall the sink for a long stretch while items keep coming, so the input backs up
    task automatic test_backpressure();
        calm = 1;
        hold_request = 150;
        for (int n = 0; n < 100; n++)
        begin
            send_item(random_item());
        end
        calm = 0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.tau_i_x = '0;
        in_ch.tau_i_y = '0;
        in_ch.tau_i_z = '0;
        in_ch.tau_j_x = '0;
        in_ch.tau_j_y = '0;
        in_ch.tau_j_z = '0;
        in_ch.ref_x   = '0;
        in_ch.ref_y   = '0;
        in_ch.ref_z   = '0;
        out_ch.ready  = 1'b0;
        metric_mirror = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, '0, '0, '0};
        period_mirror = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_field_extremes();
        test_ties_zero_metric();
        test_period_extremes();
        test_metric_extremes();
        test_random_lattices(10, 50);
        test_backpressure();

        drain();
        $display("Covered %0d items over %0d register settings, %0d results checked,",
                 sent_items, cfg_phases, checked);
        $display("including zero and extreme metrics, tied lengths and a long sink stall.");
        if (errors == 0 && expected_images.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/nps_pkg.sv
rtl/nps_if.sv
rtl/nps_prep.sv
rtl/nps_cell.sv
rtl/nearest_periodic_image_search_unit.sv
bench/tb_nearest_periodic_image_search_unit.sv
